>>> hdl/wear_leveled_log_page_allocator_defines.svh
// Assertion macros for the wear-leveled log page allocator.
`ifndef WEAR_LEVELED_LOG_PAGE_ALLOCATOR_DEFINES_SVH
`define WEAR_LEVELED_LOG_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define WLPA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wlpa same-cycle check failed");
`define WLPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wlpa next-cycle check failed");
`else
`define WLPA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define WLPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/wlpa_pkg.sv
// Package with constants and types of the wear-leveled log page allocator.
`timescale 1ns / 1ps
package wlpa_pkg;

  localparam int unsigned PAGE_BYTES   = 2048;
  localparam int unsigned PAGE_COUNT   = 8;
  localparam int unsigned RECORD_BYTES = 19;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PAGE_W     = 3;
  localparam int unsigned FILL_W     = 12;
  localparam int unsigned SUM_W      = FILL_W + 2;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0807_8000;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } wlpa_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] record_address;
    logic              erase_needed;
    logic [ADDR_W-1:0] erase_address;
    logic [PAGE_W-1:0] active_page;
    logic [FILL_W-1:0] fill_after;
  } wlpa_res_t;

endpackage

>>> hdl/wlpa_if.sv
// Handshake channel interfaces: append requests, results and base register writes.
`timescale 1ns / 1ps
interface wlpa_req_if;
  logic valid;
  logic ready;
  logic append_request;
  modport source (output valid, output append_request, input ready);
  modport sink (input valid, input append_request, output ready);
endinterface

interface wlpa_res_if;
  logic                          valid;
  logic                          ready;
  logic [wlpa_pkg::ADDR_W-1:0]   record_address;
  logic                          erase_needed;
  logic [wlpa_pkg::ADDR_W-1:0]   erase_address;
  logic [wlpa_pkg::PAGE_W-1:0]   active_page;
  logic [wlpa_pkg::FILL_W-1:0]   fill_after;
  modport source (output valid, output record_address, output erase_needed,
                  output erase_address, output active_page, output fill_after,
                  input ready);
  modport sink (input valid, input record_address, input erase_needed,
                input erase_address, input active_page, input fill_after,
                output ready);
endinterface

interface wlpa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wlpa_pkg::ADDR_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/wear_leveled_log_page_allocator.sv
// Wear-leveled log page allocator: top level.
//
// Channels: req_i carries append requests, res_o returns one result per request
// with append_request set, cfg_i writes the store base address (always ready).
// A transfer on req_i with append_request clear is consumed and gives no result.
// An append that fits the active page is registered in the work register, then
// moves to the output register once that is free. An append that overflows the
// page walks the erase counter memory one entry per cycle to find the
// least-erased page, then updates that counter. One request is in work at a
// time; the next transfer is taken as soon as the block is back in idle, even
// while a result still waits.
// When res_o is stalled, the finished result holds in the output register and a
// newer result waits in the work register until the output frees up.
// Reset puts page 0 active at offset 0, marks all erase counters as zero through
// per-entry valid bits and restores base address 0x08078000. No clearing pass.
`timescale 1ns / 1ps
`include "wear_leveled_log_page_allocator_defines.svh"
module wear_leveled_log_page_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  wlpa_req_if.sink        req_i,
  wlpa_res_if.source      res_o,
  wlpa_cfg_if.sink        cfg_i
);

  wlpa_pkg::wlpa_state_e state_q, state_d;

  logic [wlpa_pkg::ADDR_W-1:0] base_q;
  logic [wlpa_pkg::PAGE_W-1:0] page_q;
  logic [wlpa_pkg::FILL_W-1:0] fill_q;
  logic [wlpa_pkg::PAGE_W-1:0] scan_q;
  logic [wlpa_pkg::PAGE_COUNT-1:0] valid_q;
  logic                        out_valid_q;

  logic [wlpa_pkg::CNT_W-1:0]  cnt_mem [wlpa_pkg::PAGE_COUNT];
  logic [wlpa_pkg::CNT_W-1:0]  rd_data_q;
  logic                        rd_valid_q;
  logic [wlpa_pkg::PAGE_W-1:0] rd_addr;

  logic [wlpa_pkg::CNT_W-1:0]  best_q;
  logic [wlpa_pkg::PAGE_W-1:0] best_idx_q;
  logic [wlpa_pkg::CNT_W-1:0]  cur_cnt;
  logic                        take_cur;

  wlpa_pkg::wlpa_res_t res_q, res_d, out_q;

  logic                        in_xfer;
  logic                        app_xfer;
  logic                        load_out;
  logic [wlpa_pkg::SUM_W-1:0]  fill_sum;
  logic                        rotate;
  logic [wlpa_pkg::ADDR_W-1:0] cur_page_base;
  logic [wlpa_pkg::ADDR_W-1:0] best_page_base;
  logic                        mem_we;
  logic [wlpa_pkg::CNT_W-1:0]  wr_data;

  assign cfg_i.ready = 1'b1;

  assign in_xfer  = req_i.valid && req_i.ready;
  assign app_xfer = in_xfer && req_i.append_request;
  assign fill_sum = wlpa_pkg::SUM_W'(fill_q) + wlpa_pkg::SUM_W'(wlpa_pkg::RECORD_BYTES);
  assign rotate   = fill_sum > wlpa_pkg::SUM_W'(wlpa_pkg::PAGE_BYTES);

  assign cur_page_base  = base_q + (wlpa_pkg::ADDR_W'(page_q) << wlpa_pkg::PAGE_SHIFT);
  assign best_page_base = base_q + (wlpa_pkg::ADDR_W'(best_idx_q) << wlpa_pkg::PAGE_SHIFT);

  assign cur_cnt  = rd_valid_q ? rd_data_q : '0;
  assign take_cur = (scan_q == '0) || (cur_cnt < best_q);

  assign mem_we  = (state_q == wlpa_pkg::ST_UPDATE);
  assign wr_data = (best_q == wlpa_pkg::CNT_MAX) ? best_q : best_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    rd_addr     = '0;
    res_d       = res_q;
    unique case (state_q)
      wlpa_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (app_xfer) begin
          if (rotate) begin
            state_d = wlpa_pkg::ST_SCAN;
          end else begin
            res_d.record_address = cur_page_base + wlpa_pkg::ADDR_W'(fill_q);
            res_d.erase_needed   = 1'b0;
            res_d.erase_address  = '0;
            res_d.active_page    = page_q;
            res_d.fill_after     = fill_sum[wlpa_pkg::FILL_W-1:0];
            state_d              = wlpa_pkg::ST_EMIT;
          end
        end
      end
      wlpa_pkg::ST_SCAN: begin
        rd_addr = scan_q + 1'b1;
        if (scan_q == wlpa_pkg::PAGE_W'(wlpa_pkg::PAGE_COUNT - 1)) begin
          state_d = wlpa_pkg::ST_UPDATE;
        end
      end
      wlpa_pkg::ST_UPDATE: begin
        res_d.record_address = best_page_base;
        res_d.erase_needed   = 1'b1;
        res_d.erase_address  = best_page_base;
        res_d.active_page    = best_idx_q;
        res_d.fill_after     = wlpa_pkg::FILL_W'(wlpa_pkg::RECORD_BYTES);
        state_d              = wlpa_pkg::ST_EMIT;
      end
      wlpa_pkg::ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = wlpa_pkg::ST_IDLE;
        end
      end
      default: state_d = wlpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wlpa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= wlpa_pkg::BASE_RESET;
      page_q      <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        base_q <= cfg_i.data;
      end
      if (state_q == wlpa_pkg::ST_IDLE) begin
        scan_q <= '0;
        if (app_xfer && !rotate) begin
          fill_q <= fill_sum[wlpa_pkg::FILL_W-1:0];
        end
      end
      if (state_q == wlpa_pkg::ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end
      if (mem_we) begin
        page_q              <= best_idx_q;
        fill_q              <= wlpa_pkg::FILL_W'(wlpa_pkg::RECORD_BYTES);
        valid_q[best_idx_q] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The read port runs every cycle, but its data is used only in a scan; the write comes after it.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[best_idx_q] <= wr_data;
    end
    rd_data_q  <= cnt_mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == wlpa_pkg::ST_SCAN && take_cur) begin
      best_q     <= cur_cnt;
      best_idx_q <= scan_q;
    end
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.record_address = out_q.record_address;
  assign res_o.erase_needed   = out_q.erase_needed;
  assign res_o.erase_address  = out_q.erase_address;
  assign res_o.active_page    = out_q.active_page;
  assign res_o.fill_after     = out_q.fill_after;

  `WLPA_ASSERT_SAME(a_erase_matches_record, clk_i, rst_ni,
                    res_o.valid && res_o.erase_needed,
                    res_o.erase_address == res_o.record_address)
  `WLPA_ASSERT_SAME(a_count_write_nonzero, clk_i, rst_ni, mem_we, wr_data != '0)
  `WLPA_ASSERT_NEXT(a_overflow_starts_scan, clk_i, rst_ni, app_xfer && rotate,
                    state_q == wlpa_pkg::ST_SCAN && scan_q == '0)

endmodule
